>>> rtl/ahc_pkg.sv
// Shared types and constants for the altitude hold controller.
// Holds field widths, register reset values, register indexes and stage bundles.
// No dependencies; every other file imports this package.
package ahc_pkg;

    localparam int RAW_W      = 16;
    localparam int SAMPLE_W   = 17;
    localparam int AVG_W      = 17;
    localparam int BAND_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 32;
    localparam int SPEED_W    = 12;
    localparam int VEL_W      = 32;
    localparam int ESUM_W     = 48;
    localparam int FRAC_SHIFT = 21;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [RAW_W-1:0] ACCEL_OFFSET_RST  = -16'sd17978;
    localparam logic [BAND_W-1:0]       DEADBAND_RST      = 15'd1327;
    localparam logic [GAIN_W-1:0]       GAIN_P_RST        = 16'd256;
    localparam logic [GAIN_W-1:0]       GAIN_I_RST        = 16'd128;
    localparam logic [GAIN_W-1:0]       GAIN_D_RST        = 16'd256;
    localparam logic [THR_W-1:0]        SUM_THRESHOLD_RST = 32'd1638400;
    localparam logic [SPEED_W-1:0]      SPEED_LIMIT_RST   = 12'd2000;
    localparam logic [SPEED_W-1:0]      START_SPEED_RST   = 12'd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_OFFSET  = 4'd0,
        CFG_DEADBAND      = 4'd1,
        CFG_GAIN_P        = 4'd2,
        CFG_GAIN_I        = 4'd3,
        CFG_GAIN_D        = 4'd4,
        CFG_SUM_THRESHOLD = 4'd5,
        CFG_SPEED_LIMIT   = 4'd6,
        CFG_START_SPEED   = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic                    valid;
        logic                    outside;
        logic signed [AVG_W-1:0] avg;
    } avg_stage_t;

    typedef struct packed {
        logic                     valid;
        logic                     corrected;
        logic signed [VEL_W-1:0]  err;
        logic signed [VEL_W:0]    deriv;
        logic signed [ESUM_W-1:0] error_sum;
    } err_stage_t;

    typedef struct packed {
        logic                    valid;
        logic [SPEED_W-1:0]      motor_speed;
        logic                    corrected;
        logic signed [VEL_W-1:0] velocity_estimate;
    } result_t;

endpackage

>>> rtl/ahc_if.sv
// Valid/ready channel interfaces for the altitude hold controller.
// Sample input, result output and configuration write channels; uses ahc_pkg.
interface ahc_accel_if;
    import ahc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] accel_z_raw;
    modport source (output valid, output accel_z_raw, input ready);
    modport sink (input valid, input accel_z_raw, output ready);
endinterface

interface ahc_result_if;
    import ahc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [SPEED_W-1:0]      motor_speed;
    logic                    corrected;
    logic signed [VEL_W-1:0] velocity_estimate;
    modport source (output valid, output motor_speed, output corrected,
                    output velocity_estimate, input ready);
    modport sink (input valid, input motor_speed, input corrected,
                  input velocity_estimate, output ready);
endinterface

interface ahc_cfg_if;
    import ahc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ahc_window.sv
// Window accumulator and averager: offset removal, running sum, divide by WINDOW.
// Division uses an exact reciprocal multiply; also flags averages outside the deadband.
// Depends on ahc_pkg.
module ahc_window #(
    parameter int WINDOW = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             in_valid,
    input  logic signed [ahc_pkg::RAW_W-1:0] in_sample,
    input  logic signed [ahc_pkg::RAW_W-1:0] accel_offset,
    input  logic [ahc_pkg::BAND_W-1:0]       deadband,
    output ahc_pkg::avg_stage_t              avg_out
);
    import ahc_pkg::*;

    localparam int LOG_WIN = $clog2(WINDOW);
    localparam int CNT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = SAMPLE_W + LOG_WIN;
    localparam int SHIFT   = SUM_W + LOG_WIN;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW - 1);

    logic signed [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       tot_valid_reg;
    logic signed [SUM_W-1:0]    tot_reg;
    logic                       prod_valid_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic                       avg_valid_reg;
    logic                       outside_reg;
    logic signed [AVG_W-1:0]    avg_reg;

    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       accept;
    logic                       last;
    logic [SUM_W-1:0]           mag;
    logic [AVG_W-2:0]           quot;
    logic signed [AVG_W-1:0]    avg_next;
    logic signed [AVG_W:0]      avg_wide;
    logic signed [AVG_W:0]      band_wide;
    logic                       outside_next;

    assign sample   = SAMPLE_W'(in_sample) - SAMPLE_W'(accel_offset);
    assign sum_next = sum_reg + SUM_W'(sample);
    assign accept   = in_valid && advance;
    assign last     = (cnt_reg == LAST);

    assign mag = tot_reg[SUM_W-1] ? SUM_W'(-tot_reg) : SUM_W'(tot_reg);

    assign quot      = prod_reg[SHIFT +: AVG_W-1];
    assign avg_next  = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign avg_wide  = (AVG_W+1)'(avg_next);
    assign band_wide = $signed({3'b000, deadband});
    assign outside_next = (avg_wide > band_wide) || (avg_wide < -band_wide);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            cnt_reg        <= '0;
            tot_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            avg_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (accept)
            begin
                if (last)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            tot_valid_reg  <= accept && last;
            prod_valid_reg <= tot_valid_reg;
            avg_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (accept && last)
            begin
                tot_reg <= sum_next;
            end
            if (tot_valid_reg)
            begin
                prod_reg <= PROD_W'(mag) * PROD_W'(RECIP);
                neg_reg  <= tot_reg[SUM_W-1];
            end
            if (prod_valid_reg)
            begin
                avg_reg     <= avg_next;
                outside_reg <= outside_next;
            end
        end
    end

    assign avg_out.valid   = avg_valid_reg;
    assign avg_out.outside = outside_reg;
    assign avg_out.avg     = avg_reg;

    a_cnt_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST)
        else $error("sample count ran past the window length");

endmodule

>>> rtl/ahc_velocity.sv
// Velocity integrator and error tracker: saturating velocity and error sum updates.
// Produces the error, its derivative and the error sum for the gain stage.
// Depends on ahc_pkg.
module ahc_velocity (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  ahc_pkg::avg_stage_t avg_in,
    output ahc_pkg::err_stage_t err_out
);
    import ahc_pkg::*;

    localparam logic signed [VEL_W-1:0]  VEL_MAX  = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0]  VEL_MIN  = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic signed [ESUM_W-1:0] ESUM_MAX = {1'b0, {(ESUM_W-1){1'b1}}};
    localparam logic signed [ESUM_W-1:0] ESUM_MIN = {1'b1, {(ESUM_W-1){1'b0}}};

    logic signed [VEL_W-1:0]  vel_reg;
    logic                     a_valid_reg;
    logic                     a_corr_reg;
    logic signed [ESUM_W-1:0] esum_reg;
    logic signed [VEL_W-1:0]  prev_reg;
    logic                     b_valid_reg;
    logic                     b_corr_reg;
    logic signed [VEL_W-1:0]  err_reg;
    logic signed [VEL_W:0]    deriv_reg;

    logic signed [VEL_W:0]    vel_sum;
    logic signed [VEL_W-1:0]  vel_next;
    logic signed [ESUM_W:0]   esum_sum;
    logic signed [ESUM_W-1:0] esum_next;
    logic signed [VEL_W:0]    deriv_next;

    assign vel_sum = (VEL_W+1)'(vel_reg) + (VEL_W+1)'(avg_in.avg);
    always_comb
    begin
        if (vel_sum[VEL_W] != vel_sum[VEL_W-1])
        begin
            vel_next = vel_sum[VEL_W] ? VEL_MIN : VEL_MAX;
        end
        else
        begin
            vel_next = vel_sum[VEL_W-1:0];
        end
    end

    assign esum_sum = (ESUM_W+1)'(esum_reg) + (ESUM_W+1)'(vel_reg);
    always_comb
    begin
        if (esum_sum[ESUM_W] != esum_sum[ESUM_W-1])
        begin
            esum_next = esum_sum[ESUM_W] ? ESUM_MIN : ESUM_MAX;
        end
        else
        begin
            esum_next = esum_sum[ESUM_W-1:0];
        end
    end

    assign deriv_next = (VEL_W+1)'(vel_reg) - (VEL_W+1)'(prev_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg     <= '0;
            esum_reg    <= '0;
            prev_reg    <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= avg_in.valid;
            b_valid_reg <= a_valid_reg;
            if (avg_in.valid && avg_in.outside)
            begin
                vel_reg <= vel_next;
            end
            if (a_valid_reg && a_corr_reg)
            begin
                esum_reg <= esum_next;
                prev_reg <= vel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (avg_in.valid)
            begin
                a_corr_reg <= avg_in.outside;
            end
            if (a_valid_reg)
            begin
                b_corr_reg <= a_corr_reg;
                err_reg    <= vel_reg;
                deriv_reg  <= deriv_next;
            end
        end
    end

    assign err_out.valid     = b_valid_reg;
    assign err_out.corrected = b_corr_reg;
    assign err_out.err       = err_reg;
    assign err_out.deriv     = deriv_reg;
    assign err_out.error_sum = esum_reg;

    a_prev_tracks_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_out.valid && err_out.corrected |-> prev_reg == err_reg)
        else $error("previous error does not match the error of a corrected window");

endmodule

>>> rtl/ahc_pd.sv
// Gain stage and speed update: P, D and thresholded extra gain products, power sum,
// fixed-point speed correction with clamping, and the result register. Depends on ahc_pkg.
module ahc_pd (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  ahc_pkg::err_stage_t              err_in,
    input  logic [ahc_pkg::GAIN_W-1:0]       gain_p,
    input  logic [ahc_pkg::GAIN_W-1:0]       gain_i,
    input  logic [ahc_pkg::GAIN_W-1:0]       gain_d,
    input  logic [ahc_pkg::THR_W-1:0]        sum_threshold,
    input  logic [ahc_pkg::SPEED_W-1:0]      speed_limit,
    output ahc_pkg::result_t                 result
);
    import ahc_pkg::*;

    localparam int PE_W  = GAIN_W + 1 + VEL_W;
    localparam int PD_W  = GAIN_W + 1 + VEL_W + 1;
    localparam int PW_W  = PD_W + 2;
    localparam int TOT_W = PW_W + 2;
    localparam int HI_W  = TOT_W - 1 - FRAC_SHIFT;

    logic                     m_valid_reg;
    logic                     m_corr_reg;
    logic signed [VEL_W-1:0]  m_vel_reg;
    logic signed [PE_W-1:0]   pp_reg;
    logic signed [PE_W-1:0]   pi_reg;
    logic signed [PD_W-1:0]   pd_reg;
    logic                     hit_reg;
    logic                     s_valid_reg;
    logic                     s_corr_reg;
    logic signed [VEL_W-1:0]  s_vel_reg;
    logic signed [PW_W-1:0]   power_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic                     res_valid_reg;
    logic [SPEED_W-1:0]       res_speed_reg;
    logic                     res_corr_reg;
    logic signed [VEL_W-1:0]  res_vel_reg;

    logic [ESUM_W-1:0]        esum_mag;
    logic signed [PW_W-1:0]   power_next;
    logic signed [TOT_W-1:0]  total;
    logic [HI_W-1:0]          total_hi;
    logic [SPEED_W-1:0]       corr_speed;
    logic [SPEED_W-1:0]       speed_next;

    assign esum_mag = err_in.error_sum[ESUM_W-1] ? ESUM_W'(-err_in.error_sum)
                                                 : ESUM_W'(err_in.error_sum);

    assign power_next = PW_W'(pp_reg) + PW_W'(pd_reg)
                      + (hit_reg ? PW_W'(pi_reg) : PW_W'(0));

    assign total    = $signed(TOT_W'({speed_reg, {FRAC_SHIFT{1'b0}}})) + TOT_W'(power_reg);
    assign total_hi = total[TOT_W-2:FRAC_SHIFT];

    always_comb
    begin
        if (total[TOT_W-1] || (total == '0))
        begin
            corr_speed = '0;
        end
        else if (total_hi > HI_W'(speed_limit))
        begin
            corr_speed = speed_limit;
        end
        else
        begin
            corr_speed = total_hi[SPEED_W-1:0];
        end
        speed_next = s_corr_reg ? corr_speed : speed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            speed_reg     <= START_SPEED_RST;
        end
        else if (advance)
        begin
            m_valid_reg   <= err_in.valid;
            s_valid_reg   <= m_valid_reg;
            res_valid_reg <= s_valid_reg;
            if (s_valid_reg)
            begin
                speed_reg <= speed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (err_in.valid)
            begin
                m_corr_reg <= err_in.corrected;
                m_vel_reg  <= err_in.err;
                pp_reg     <= PE_W'($signed({1'b0, gain_p})) * PE_W'(err_in.err);
                pi_reg     <= PE_W'($signed({1'b0, gain_i})) * PE_W'(err_in.err);
                pd_reg     <= PD_W'($signed({1'b0, gain_d})) * PD_W'(err_in.deriv);
                hit_reg    <= esum_mag >= ESUM_W'(sum_threshold);
            end
            if (m_valid_reg)
            begin
                s_corr_reg <= m_corr_reg;
                s_vel_reg  <= m_vel_reg;
                power_reg  <= power_next;
            end
            if (s_valid_reg)
            begin
                res_speed_reg <= speed_next;
                res_corr_reg  <= s_corr_reg;
                res_vel_reg   <= s_vel_reg;
            end
        end
    end

    assign result.valid             = res_valid_reg;
    assign result.motor_speed       = res_speed_reg;
    assign result.corrected         = res_corr_reg;
    assign result.velocity_estimate = res_vel_reg;

    a_result_is_speed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_speed_reg == speed_reg)
        else $error("reported speed differs from the speed state");

    a_corrected_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) && res_corr_reg |-> res_speed_reg <= speed_limit)
        else $error("corrected speed above the limit");

endmodule

>>> rtl/altitude_hold_controller.sv
// Altitude hold controller top level: configuration registers, channel glue and stages.
// Instantiates ahc_window, ahc_velocity and ahc_pd; uses ahc_pkg and ahc_if.
//
//   Channel | Dir | Payload                                          | Handshake
//   --------+-----+--------------------------------------------------+----------
//   accel   | in  | accel_z_raw                                      | valid/ready
//   result  | out | motor_speed, corrected, velocity_estimate        | valid/ready
//   cfg     | in  | index, data (register write)                     | valid/ready
//
// One sample is taken every cycle unless a waiting result holds the chain; every WINDOW
// samples give one result item. Registered stages: window total, reciprocal multiply,
// average, saturating velocity update, error and saturating error sum, gain multipliers,
// power sum and speed result. Reset loads the register defaults and the start speed.
// While a result waits on result.ready, the whole chain holds and accel.ready is low.
// Configuration writes complete in the cycle they are presented.
module altitude_hold_controller #(
    parameter int WINDOW = 5
) (
    input logic          clk,
    input logic          rst_n,
    ahc_accel_if.sink    accel,
    ahc_result_if.source result,
    ahc_cfg_if.sink      cfg
);
    import ahc_pkg::*;

    logic signed [RAW_W-1:0] accel_offset_reg;
    logic [BAND_W-1:0]       deadband_reg;
    logic [GAIN_W-1:0]       gain_p_reg;
    logic [GAIN_W-1:0]       gain_i_reg;
    logic [GAIN_W-1:0]       gain_d_reg;
    logic [THR_W-1:0]        sum_threshold_reg;
    logic [SPEED_W-1:0]      speed_limit_reg;

    logic       advance;
    avg_stage_t avg_stage;
    err_stage_t err_stage;
    result_t    res;

    assign advance     = !(res.valid && !result.ready);
    assign accel.ready = advance;
    assign cfg.ready   = 1'b1;

    // The start speed only matters at reset, where its default is loaded, so a write to
    // it is taken and has no further effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_offset_reg  <= ACCEL_OFFSET_RST;
            deadband_reg      <= DEADBAND_RST;
            gain_p_reg        <= GAIN_P_RST;
            gain_i_reg        <= GAIN_I_RST;
            gain_d_reg        <= GAIN_D_RST;
            sum_threshold_reg <= SUM_THRESHOLD_RST;
            speed_limit_reg   <= SPEED_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_ACCEL_OFFSET:  accel_offset_reg  <= cfg.data[RAW_W-1:0];
                CFG_DEADBAND:      deadband_reg      <= cfg.data[BAND_W-1:0];
                CFG_GAIN_P:        gain_p_reg        <= cfg.data[GAIN_W-1:0];
                CFG_GAIN_I:        gain_i_reg        <= cfg.data[GAIN_W-1:0];
                CFG_GAIN_D:        gain_d_reg        <= cfg.data[GAIN_W-1:0];
                CFG_SUM_THRESHOLD: sum_threshold_reg <= cfg.data[THR_W-1:0];
                CFG_SPEED_LIMIT:   speed_limit_reg   <= cfg.data[SPEED_W-1:0];
                default:           ;
            endcase
        end
    end

    ahc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (accel.valid),
        .in_sample    (accel.accel_z_raw),
        .accel_offset (accel_offset_reg),
        .deadband     (deadband_reg),
        .avg_out      (avg_stage)
    );

    ahc_velocity u_velocity (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .avg_in  (avg_stage),
        .err_out (err_stage)
    );

    ahc_pd u_pd (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .err_in        (err_stage),
        .gain_p        (gain_p_reg),
        .gain_i        (gain_i_reg),
        .gain_d        (gain_d_reg),
        .sum_threshold (sum_threshold_reg),
        .speed_limit   (speed_limit_reg),
        .result        (res)
    );

    assign result.valid             = res.valid;
    assign result.motor_speed       = res.motor_speed;
    assign result.corrected         = res.corrected;
    assign result.velocity_estimate = res.velocity_estimate;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for altitude_hold_controller: directed windows, random
// register phases, back-pressure and a full-scale run, checked by a predictor.
// Depends on ahc_pkg, the channel interfaces in ahc_if and the controller RTL.
module tb;
    import ahc_pkg::*;

    localparam int WINDOW            = 5;
    localparam int LATENCY           = 8;
    localparam int QUIET_LIMIT       = 2000;
    localparam int HOLD_CYCLES       = 300;
    localparam int MAX_PRINTS        = 100;
    localparam int RANDOM_PHASES     = 10;
    localparam int WINDOWS_PER_PHASE = 7;
    localparam int RISE_WINDOWS      = 20;
    localparam int FALL_WINDOWS      = 20;
    localparam int EDGE_BAND         = 100;
    localparam int LOW_LIMIT         = 1000;

    localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W - 1){1'b1}}};
    localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W - 1){1'b0}}};
    localparam longint VEL_HI  = (longint'(1) <<< (VEL_W - 1)) - 1;
    localparam longint VEL_LO  = -(longint'(1) <<< (VEL_W - 1));
    localparam longint ESUM_HI = (longint'(1) <<< (ESUM_W - 1)) - 1;
    localparam longint ESUM_LO = -(longint'(1) <<< (ESUM_W - 1));

    typedef struct {
        logic [SPEED_W-1:0]      motor_speed;
        logic                    corrected;
        logic signed [VEL_W-1:0] velocity_estimate;
    } window_report_t;

    logic clk = 1'b0;
    logic rst_n;

    ahc_accel_if  accel_if ();
    ahc_result_if result_if ();
    ahc_cfg_if    cfg_if ();

    altitude_hold_controller #(
        .WINDOW (WINDOW)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .accel  (accel_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    logic signed [RAW_W-1:0] offset_q;
    logic [BAND_W-1:0]       band_q;
    logic [GAIN_W-1:0]       kp_q;
    logic [GAIN_W-1:0]       ki_q;
    logic [GAIN_W-1:0]       kd_q;
    logic [THR_W-1:0]        threshold_q;
    logic [SPEED_W-1:0]      limit_q;
    logic [SPEED_W-1:0]      start_q;
    longint                  window_acc;
    int                      window_fill;
    longint                  vel_q;
    longint                  last_err_q;
    longint                  err_sum_q;
    longint                  speed_q;

    window_report_t pending_reports [$];
    int             error_count  = 0;
    int             quiet_cycles = 0;
    bit             steady       = 1'b0;
    bit             hold_request = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void load_reset_state();
        offset_q    = ACCEL_OFFSET_RST;
        band_q      = DEADBAND_RST;
        kp_q        = GAIN_P_RST;
        ki_q        = GAIN_I_RST;
        kd_q        = GAIN_D_RST;
        threshold_q = SUM_THRESHOLD_RST;
        limit_q     = SPEED_LIMIT_RST;
        start_q     = START_SPEED_RST;
        window_acc  = 0;
        window_fill = 0;
        vel_q       = 0;
        last_err_q  = 0;
        err_sum_q   = 0;
        speed_q     = longint'(start_q);
    endfunction

    function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ACCEL_OFFSET:  offset_q    = data[RAW_W-1:0];
            CFG_DEADBAND:      band_q      = data[BAND_W-1:0];
            CFG_GAIN_P:        kp_q        = data[GAIN_W-1:0];
            CFG_GAIN_I:        ki_q        = data[GAIN_W-1:0];
            CFG_GAIN_D:        kd_q        = data[GAIN_W-1:0];
            CFG_SUM_THRESHOLD: threshold_q = data[THR_W-1:0];
            CFG_SPEED_LIMIT:   limit_q     = data[SPEED_W-1:0];
            CFG_START_SPEED:   start_q     = data[SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    // One accepted sample; a completed window yields one expected report.
    function automatic void fold_sample(input logic signed [RAW_W-1:0] raw);
        longint         avg;
        longint         err;
        longint         deriv;
        longint         power;
        longint         total;
        longint         mag;
        window_report_t rep;
        window_acc  = window_acc + longint'(raw) - longint'(offset_q);
        window_fill = window_fill + 1;
        if (window_fill < WINDOW)
            return;
        avg         = window_acc / WINDOW;
        window_acc  = 0;
        window_fill = 0;
        rep.corrected = 1'b0;
        if (avg > longint'(band_q) || avg < -longint'(band_q))
        begin
            vel_q     = clip(vel_q + avg, VEL_LO, VEL_HI);
            err       = vel_q;
            deriv     = err - last_err_q;
            err_sum_q = clip(err_sum_q + err, ESUM_LO, ESUM_HI);
            mag       = (err_sum_q < 0) ? -err_sum_q : err_sum_q;
            power     = longint'(kp_q) * err + longint'(kd_q) * deriv;
            if (mag >= longint'(threshold_q))
                power = power + longint'(ki_q) * err;
            total = (speed_q <<< FRAC_SHIFT) + power;
            if (total <= 0)
                speed_q = 0;
            else
                speed_q = total >>> FRAC_SHIFT;
            if (speed_q > longint'(limit_q))
                speed_q = longint'(limit_q);
            last_err_q    = err;
            rep.corrected = 1'b1;
        end
        rep.motor_speed       = speed_q[SPEED_W-1:0];
        rep.velocity_estimate = vel_q[VEL_W-1:0];
        pending_reports.push_back(rep);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_report();
        window_report_t want;
        if (pending_reports.size() == 0)
        begin
            report_mismatch("result with no window pending", longint'(result_if.motor_speed),
                            longint'(0));
            return;
        end
        want = pending_reports.pop_front();
        if (result_if.motor_speed !== want.motor_speed)
            report_mismatch("motor_speed", longint'(result_if.motor_speed),
                            longint'(want.motor_speed));
        if (result_if.corrected !== want.corrected)
            report_mismatch("corrected", longint'(result_if.corrected),
                            longint'(want.corrected));
        if (result_if.velocity_estimate !== want.velocity_estimate)
            report_mismatch("velocity_estimate", longint'(result_if.velocity_estimate),
                            longint'(want.velocity_estimate));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_if.valid && cfg_if.ready)
                apply_register_write(cfg_if.index, cfg_if.data);
            if (accel_if.valid && accel_if.ready)
                fold_sample(accel_if.accel_z_raw);
            if (result_if.valid && result_if.ready)
                check_report();
        end
    end

    always @(posedge clk)
    begin
        if ((accel_if.valid && accel_if.ready) || (result_if.valid && result_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
                stall_left = idle_length();
            if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic signed [RAW_W-1:0] raw);
        int unsigned gap;
        gap = (!steady && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0)
        begin
            accel_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        accel_if.valid       <= 1'b1;
        accel_if.accel_z_raw <= raw;
        do @(posedge clk); while (accel_if.ready !== 1'b1);
    endtask

    // Lets every pending report arrive and the pipeline empty out.
    task automatic settle();
        accel_if.valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [RAW_W-1:0] any_raw();
        return RAW_W'($urandom);
    endfunction

    function automatic logic signed [RAW_W-1:0] raw_near(input int target);
        int v;
        v = target + int'(offset_q) + int'($urandom_range(0, 64)) - 32;
        if (v > int'(RAW_MAX))
            v = int'(RAW_MAX);
        if (v < int'(RAW_MIN))
            v = int'(RAW_MIN);
        return RAW_W'(v);
    endfunction

    function automatic int pick_average();
        int band;
        band = int'(band_q);
        if ($urandom_range(0, 4) == 0)
            return int'($urandom_range(0, 131070)) - 65535;
        return int'($urandom_range(0, 2 * band + 400)) - (band + 200);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int width, input int phase);
        logic [CFG_DATA_W-1:0] all_ones;
        all_ones = {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - width);
        if (phase == 0)
            return '0;
        if (phase == 1)
            return all_ones;
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return all_ones;
            2:       return $urandom_range(0, 8);
            3:       return $urandom;
            default: return $urandom_range(0, 4095) & all_ones;
        endcase
    endfunction

    task automatic randomize_registers(input int phase);
        logic [CFG_DATA_W-1:0] offset;
        if (phase == 0)
            offset = CFG_DATA_W'(RAW_MIN);
        else if (phase == 1)
            offset = CFG_DATA_W'(RAW_MAX);
        else if ($urandom_range(0, 1) == 0)
            offset = $urandom;
        else
            offset = CFG_DATA_W'(int'($urandom_range(0, 4000)) - 2000);
        write_register(CFG_ACCEL_OFFSET, offset);
        write_register(CFG_DEADBAND, pick_setting(BAND_W, phase));
        write_register(CFG_GAIN_P, pick_setting(GAIN_W, phase));
        write_register(CFG_GAIN_I, pick_setting(GAIN_W, phase));
        write_register(CFG_GAIN_D, pick_setting(GAIN_W, phase));
        write_register(CFG_SUM_THRESHOLD, pick_setting(THR_W, phase));
        write_register(CFG_SPEED_LIMIT, pick_setting(SPEED_W, phase));
        write_register(CFG_START_SPEED, pick_setting(SPEED_W, phase));
    endtask

    task automatic test_field_extremes();
        repeat (WINDOW) send_sample(RAW_MAX);
        repeat (WINDOW) send_sample(RAW_MIN);
    endtask

    // The limit drops below the current speed, so the in-band window reports a speed
    // above it; the next window sums to a fraction that must truncate toward zero.
    task automatic test_deadband_and_rounding();
        settle();
        write_register(CFG_ACCEL_OFFSET, '0);
        write_register(CFG_DEADBAND, EDGE_BAND);
        write_register(CFG_GAIN_P, '1);
        write_register(CFG_GAIN_D, '0);
        write_register(CFG_SPEED_LIMIT, LOW_LIMIT);
        repeat (WINDOW) send_sample(RAW_W'(EDGE_BAND));
        repeat (WINDOW - 1) send_sample(RAW_W'(-(EDGE_BAND + 1)));
        send_sample(RAW_W'(-(EDGE_BAND + 5)));
    endtask

    task automatic test_speed_floor();
        settle();
        write_register(CFG_ACCEL_OFFSET, CFG_DATA_W'(RAW_MAX));
        write_register(CFG_GAIN_D, '1);
        repeat (WINDOW) send_sample(RAW_MIN);
    endtask

    task automatic test_register_writes();
        settle();
        write_register(CFG_START_SPEED, '1);
        for (int idx = CFG_START_SPEED + 1; idx < (1 << CFG_IDX_W); idx++)
            write_register(CFG_IDX_W'(idx), '1);
        write_register(CFG_SUM_THRESHOLD, '0);
        write_register(CFG_GAIN_I, '1);
        write_register(CFG_ACCEL_OFFSET, '0);
        write_register(CFG_SPEED_LIMIT, '1);
        repeat (WINDOW) send_sample(RAW_MAX);
    endtask

    task automatic test_backpressure();
        settle();
        write_register(CFG_DEADBAND, '0);
        hold_request = 1'b1;
        steady       = 1'b1;
        repeat (12 * WINDOW) send_sample(any_raw());
        steady = 1'b0;
        settle();
    endtask

    task automatic test_random_phases();
        int target;
        bit noisy;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            steady = (phase % 4 == 3);
            randomize_registers(phase);
            for (int w = 0; w < WINDOWS_PER_PHASE; w++)
            begin
                noisy  = ($urandom_range(0, 6) == 0);
                target = pick_average();
                for (int k = 0; k < WINDOW; k++)
                    send_sample(noisy ? any_raw() : raw_near(target));
            end
        end
        steady = 1'b0;
        settle();
    endtask

    // Full-scale windows with every gain at full scale push the velocity up quickly,
    // then full-scale windows of the other sign drive it back down.
    task automatic test_saturation();
        settle();
        write_register(CFG_ACCEL_OFFSET, CFG_DATA_W'(RAW_MIN));
        write_register(CFG_DEADBAND, '0);
        write_register(CFG_GAIN_P, '1);
        write_register(CFG_GAIN_I, '1);
        write_register(CFG_GAIN_D, '1);
        write_register(CFG_SPEED_LIMIT, SPEED_LIMIT_RST);
        steady = 1'b1;
        repeat (RISE_WINDOWS * WINDOW) send_sample(RAW_MAX);
        settle();
        write_register(CFG_ACCEL_OFFSET, CFG_DATA_W'(RAW_MAX));
        repeat (FALL_WINDOWS * WINDOW) send_sample(RAW_MIN);
        steady = 1'b0;
        settle();
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        accel_if.valid       <= 1'b0;
        accel_if.accel_z_raw <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_ACCEL_OFFSET;
        cfg_if.data          <= '0;
        load_reset_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_deadband_and_rounding();
        test_speed_floor();
        test_register_writes();
        test_backpressure();
        test_random_phases();
        test_saturation();
        settle();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
